// File: sv/hzp_pkg.sv
// Shared types, constants and helper functions for the hierarchical-Z pyramid.
`timescale 1ns / 1ps

package hzp_pkg;

    // Default sizes of the largest frame and of one stored depth value.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_DEPTH_BITS = 24;

    // Fixed field widths of the request, response and configuration port.
    localparam int ACTION_W  = 2;
    localparam int LEVEL_W   = 4;
    localparam int COORD_W   = 10;
    localparam int DEPTH_W   = 24;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Every level code the request can carry gets an offset slot.
    localparam int NUM_LEVEL_SLOTS = 1 << LEVEL_W;

    localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BUILD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    typedef logic [DIM_W-1:0]    t_dim;
    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [ACTION_W-1:0] t_action;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic calc;
        logic init_build;
        logic wr_pix;
        logic rd_pix;
        logic row_calc;
        logic rd_a;
        logic rd_b;
        logic wr_texel;
        logic load_result;
    } t_hzp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        t_action action;
        logic    oob;
        logic    single_level;
        logic    row_end;
        logic    build_end;
    } t_hzp_stat;

    // Extent of a level: the base extent halved l times, rounding up.
    function automatic t_dim hzp_extent(input t_dim v, input t_level l);
        t_dim mask;
        mask = ~({DIM_W{1'b1}} << l);
        return (v >> l) + t_dim'(|(v & mask));
    endfunction

    // Number of levels: one plus the bit length of (size - 1).
    function automatic t_level hzp_level_count(input t_dim s);
        t_dim   d;
        t_level n;
        d = s - t_dim'(1);
        n = t_level'(1);
        for (int i = 0; i < DIM_W; i++) begin
            if (d[i]) begin
                n = t_level'(i + 2);
            end
        end
        return n;
    endfunction

    // Elaboration-time extent for sizing the store.
    function automatic int hzp_ext_int(input int v, input int l);
        int e;
        e = v;
        for (int i = 0; i < l; i++) begin
            e = (e + 1) >> 1;
        end
        return e;
    endfunction

    // Elaboration-time start of a level's region, sized for the largest frame.
    function automatic int hzp_level_offset(input int mw, input int mh, input int l);
        int off;
        off = 0;
        for (int k = 0; k < l; k++) begin
            off += hzp_ext_int(mw, k) * hzp_ext_int(mh, k);
        end
        return off;
    endfunction

endpackage

// File: sv/hzp_req_if.sv
// Request channel: valid/ready handshake with the action and its operands.
`timescale 1ns / 1ps

interface hzp_req_if;
    logic                          valid;
    logic                          ready;
    logic [hzp_pkg::ACTION_W-1:0]  action;
    logic                          pyramid_select;
    logic [hzp_pkg::LEVEL_W-1:0]   mip_level;
    logic [hzp_pkg::COORD_W-1:0]   coord_x;
    logic [hzp_pkg::COORD_W-1:0]   coord_y;
    logic [hzp_pkg::DEPTH_W-1:0]   depth_in;

    modport source (
        output valid, action, pyramid_select, mip_level, coord_x, coord_y, depth_in,
        input  ready
    );

    modport sink (
        input  valid, action, pyramid_select, mip_level, coord_x, coord_y, depth_in,
        output ready
    );
endinterface

// File: sv/hzp_rsp_if.sv
// Response channel: valid/ready handshake with the sampled depth and status.
`timescale 1ns / 1ps

interface hzp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [hzp_pkg::DEPTH_W-1:0] depth_out;
    logic                        status;

    modport source (
        output valid, depth_out, status,
        input  ready
    );

    modport sink (
        input  valid, depth_out, status,
        output ready
    );
endinterface

// File: sv/hzp_ctrl.sv
// Controller state machine that sequences writes, samples and pyramid builds.
`timescale 1ns / 1ps

module hzp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    input  hzp_pkg::t_hzp_stat   i_stat,
    output hzp_pkg::t_hzp_cmd    o_cmd
);
    import hzp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CALC = 4'd1;
    localparam logic [3:0] S_WPIX = 4'd2;
    localparam logic [3:0] S_SRD  = 4'd3;
    localparam logic [3:0] S_ROW  = 4'd4;
    localparam logic [3:0] S_RDA  = 4'd5;
    localparam logic [3:0] S_RDB  = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_RES  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_rsp_valid;
    logic       n_rsp_valid;
    t_hzp_cmd   cmd;
    logic       req_ready;

    always_comb begin
        n_state   = r_state;
        cmd       = '0;
        req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                req_ready = 1'b1;
                if (i_req_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                cmd.calc = 1'b1;
                case (i_stat.action)
                    ACT_WRITE: begin
                        n_state = S_WPIX;
                    end
                    ACT_BUILD: begin
                        if (i_stat.single_level) begin
                            n_state = S_RES;
                        end else begin
                            cmd.init_build = 1'b1;
                            n_state        = S_ROW;
                        end
                    end
                    ACT_SAMPLE: begin
                        n_state = i_stat.oob ? S_RES : S_SRD;
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end
            S_WPIX: begin
                cmd.wr_pix = 1'b1;
                n_state    = S_RES;
            end
            S_SRD: begin
                cmd.rd_pix = 1'b1;
                n_state    = S_RES;
            end
            S_ROW: begin
                cmd.row_calc = 1'b1;
                n_state      = S_RDA;
            end
            S_RDA: begin
                cmd.rd_a = 1'b1;
                n_state  = S_RDB;
            end
            S_RDB: begin
                cmd.rd_b = 1'b1;
                n_state  = S_WR;
            end
            S_WR: begin
                cmd.wr_texel = 1'b1;
                if (i_stat.build_end) begin
                    n_state = S_RES;
                end else if (i_stat.row_end) begin
                    n_state = S_ROW;
                end else begin
                    n_state = S_RDA;
                end
            end
            S_RES: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    cmd.load_result = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        if (cmd.load_result) begin
            n_rsp_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_req_ready = req_ready;
    assign o_rsp_valid = r_rsp_valid;

endmodule

// File: sv/hzp_datapath.sv
// Datapath: frame registers, pyramid store, address arithmetic and 2x2 minimum.
`timescale 1ns / 1ps

module hzp_datapath #(
    parameter int MAX_WIDTH  = hzp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hzp_pkg::DEF_MAX_HEIGHT,
    parameter int DEPTH_BITS = hzp_pkg::DEF_DEPTH_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hzp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hzp_pkg::DIM_W-1:0]       i_cfg_data,
    input  logic [hzp_pkg::ACTION_W-1:0]    i_action,
    input  logic                            i_pyramid_select,
    input  logic [hzp_pkg::LEVEL_W-1:0]     i_mip_level,
    input  logic [hzp_pkg::COORD_W-1:0]     i_coord_x,
    input  logic [hzp_pkg::COORD_W-1:0]     i_coord_y,
    input  logic [hzp_pkg::DEPTH_W-1:0]     i_depth_in,
    input  hzp_pkg::t_hzp_cmd               i_cmd,
    output hzp_pkg::t_hzp_stat              o_stat,
    output logic [hzp_pkg::DEPTH_W-1:0]     o_depth_out,
    output logic                            o_status
);
    import hzp_pkg::*;

    localparam int TOTAL     = hzp_level_offset(MAX_WIDTH, MAX_HEIGHT, NUM_LEVEL_SLOTS);
    localparam int MEM_DEPTH = 2 * TOTAL;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int PROD_W    = COORD_W + DIM_W;
    localparam t_dim RST_W   = (MAX_WIDTH < 256) ? t_dim'(MAX_WIDTH) : t_dim'(256);
    localparam t_dim RST_H   = (MAX_HEIGHT < 256) ? t_dim'(MAX_HEIGHT) : t_dim'(256);

    // Frame size registers.
    t_dim r_frame_w;
    t_dim r_frame_h;
    t_dim cfg_w_clamped;
    t_dim cfg_h_clamped;

    always_comb begin
        cfg_w_clamped = i_cfg_data;
        cfg_h_clamped = i_cfg_data;
        if (i_cfg_data == '0) begin
            cfg_w_clamped = t_dim'(1);
            cfg_h_clamped = t_dim'(1);
        end else begin
            if (32'(i_cfg_data) > MAX_WIDTH) begin
                cfg_w_clamped = t_dim'(MAX_WIDTH);
            end
            if (32'(i_cfg_data) > MAX_HEIGHT) begin
                cfg_h_clamped = t_dim'(MAX_HEIGHT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= RST_W;
            r_frame_h <= RST_H;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_w <= cfg_w_clamped;
                REG_FRAME_HEIGHT: r_frame_h <= cfg_h_clamped;
                default: begin
                end
            endcase
        end
    end

    // Level region offsets within one pyramid.
    logic [AW-1:0] off_tab [NUM_LEVEL_SLOTS];

    for (genvar g = 0; g < NUM_LEVEL_SLOTS; g++) begin : g_off
        assign off_tab[g] = AW'(hzp_level_offset(MAX_WIDTH, MAX_HEIGHT, g));
    end

    t_dim   frame_max;
    t_level level_n;

    assign frame_max = (r_frame_w > r_frame_h) ? r_frame_w : r_frame_h;
    assign level_n   = hzp_level_count(frame_max);

    // Latched request.
    t_action                r_action;
    logic                   r_sel;
    t_level                 r_level;
    logic [COORD_W-1:0]     r_cx;
    logic [COORD_W-1:0]     r_cy;
    logic [DEPTH_BITS-1:0]  r_depth;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_sel    <= i_pyramid_select;
            r_level  <= i_mip_level;
            r_cx     <= i_coord_x;
            r_cy     <= i_coord_y;
            r_depth  <= DEPTH_BITS'(i_depth_in);
        end
    end

    logic [AW-1:0] sel_base;
    assign sel_base = r_sel ? AW'(TOTAL) : '0;

    // Address and range check for a single-pixel write or sample.
    t_level             lvl_item;
    t_dim               item_w;
    t_dim               item_h;
    logic               item_oob;
    logic [PROD_W-1:0]  item_prod;
    logic [AW-1:0]      item_addr;

    assign lvl_item  = (r_action == ACT_SAMPLE) ? r_level : '0;
    assign item_w    = hzp_extent(r_frame_w, lvl_item);
    assign item_h    = hzp_extent(r_frame_h, lvl_item);
    assign item_oob  = (lvl_item >= level_n)
                    || (r_cx >= COORD_W'(item_w))
                    || (r_cy >= COORD_W'(item_h));
    assign item_prod = r_cy * item_w;
    assign item_addr = sel_base + off_tab[lvl_item] + AW'(item_prod) + AW'(r_cx);

    logic [AW-1:0] r_addr;
    logic          r_oob;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_addr <= item_addr;
            r_oob  <= item_oob;
        end
    end

    // Build walk: output texel (r_x, r_y) of level r_lvl.
    t_level r_lvl;
    t_dim   r_x;
    t_dim   r_y;
    t_level lvl_prev;
    t_dim   pw;
    t_dim   ph;
    t_dim   ow;
    t_dim   oh;
    t_dim   pw_m1;
    t_dim   ph_m1;
    logic [DIM_W:0] two_x;
    logic [DIM_W:0] two_y;
    logic [DIM_W:0] x0_p1;
    logic [DIM_W:0] y0_p1;
    t_dim   x0;
    t_dim   x1;
    t_dim   y0;
    t_dim   y1;
    logic   row_end;
    logic   level_end;
    logic   build_end;

    assign lvl_prev = r_lvl - t_level'(1);
    assign pw       = hzp_extent(r_frame_w, lvl_prev);
    assign ph       = hzp_extent(r_frame_h, lvl_prev);
    assign ow       = hzp_extent(r_frame_w, r_lvl);
    assign oh       = hzp_extent(r_frame_h, r_lvl);
    assign pw_m1    = pw - t_dim'(1);
    assign ph_m1    = ph - t_dim'(1);
    assign two_x    = {r_x, 1'b0};
    assign two_y    = {r_y, 1'b0};
    assign x0       = (two_x < {1'b0, pw_m1}) ? two_x[DIM_W-1:0] : pw_m1;
    assign y0       = (two_y < {1'b0, ph_m1}) ? two_y[DIM_W-1:0] : ph_m1;
    assign x0_p1    = {1'b0, x0} + (DIM_W + 1)'(1);
    assign y0_p1    = {1'b0, y0} + (DIM_W + 1)'(1);
    assign x1       = (x0_p1 < {1'b0, pw_m1}) ? x0_p1[DIM_W-1:0] : pw_m1;
    assign y1       = (y0_p1 < {1'b0, ph_m1}) ? y0_p1[DIM_W-1:0] : ph_m1;

    assign row_end   = (r_x == ow - t_dim'(1));
    assign level_end = row_end && (r_y == oh - t_dim'(1));
    assign build_end = level_end && (r_lvl == level_n - t_level'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_build) begin
            r_lvl <= t_level'(1);
            r_x   <= '0;
            r_y   <= '0;
        end else if (i_cmd.wr_texel) begin
            if (row_end) begin
                r_x <= '0;
                if (level_end) begin
                    r_y   <= '0;
                    r_lvl <= r_lvl + t_level'(1);
                end else begin
                    r_y <= r_y + t_dim'(1);
                end
            end else begin
                r_x <= r_x + t_dim'(1);
            end
        end
    end

    // Row bases of the two source rows and of the output row.
    logic [2*DIM_W-1:0] prod_a;
    logic [2*DIM_W-1:0] prod_b;
    logic [2*DIM_W-1:0] prod_w;
    logic [AW-1:0]      r_rowa;
    logic [AW-1:0]      r_rowb;
    logic [AW-1:0]      r_wrow;

    assign prod_a = y0 * pw;
    assign prod_b = y1 * pw;
    assign prod_w = r_y * ow;

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_calc) begin
            r_rowa <= sel_base + off_tab[lvl_prev] + AW'(prod_a);
            r_rowb <= sel_base + off_tab[lvl_prev] + AW'(prod_b);
            r_wrow <= sel_base + off_tab[r_lvl] + AW'(prod_w);
        end
    end

    // Pyramid store: one write port, two registered read ports.
    logic [DEPTH_BITS-1:0] mem [MEM_DEPTH];
    logic [DEPTH_BITS-1:0] r_q0;
    logic [DEPTH_BITS-1:0] r_q1;
    logic [DEPTH_BITS-1:0] r_ab;
    logic [DEPTH_BITS-1:0] min_q;
    logic [DEPTH_BITS-1:0] texel_min;
    logic [AW-1:0]         rd_row;
    logic [AW-1:0]         ra0;
    logic [AW-1:0]         ra1;
    logic [AW-1:0]         wa;
    logic [DEPTH_BITS-1:0] wd;
    logic                  rd_en;
    logic                  we;

    assign min_q     = (r_q0 < r_q1) ? r_q0 : r_q1;
    assign texel_min = (r_ab < min_q) ? r_ab : min_q;

    assign rd_row = i_cmd.rd_a ? r_rowa : r_rowb;
    assign ra0    = i_cmd.rd_pix ? r_addr : rd_row + AW'(x0);
    assign ra1    = rd_row + AW'(x1);
    assign rd_en  = i_cmd.rd_pix || i_cmd.rd_a || i_cmd.rd_b;
    assign we     = (i_cmd.wr_pix && !r_oob) || i_cmd.wr_texel;
    assign wa     = i_cmd.wr_pix ? r_addr : r_wrow + AW'(r_x);
    assign wd     = i_cmd.wr_pix ? r_depth : texel_min;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_q0 <= mem[ra0];
            r_q1 <= mem[ra1];
        end
    end

    // The first pair of the 2x2 block is reduced while the second is read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_b) begin
            r_ab <= min_q;
        end
    end

    // Response payload register.
    logic [DEPTH_W-1:0] r_depth_out;
    logic               r_status_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_depth_out  <= (r_action == ACT_SAMPLE && !r_oob) ? DEPTH_W'(r_q0) : '0;
            r_status_out <= (r_action == ACT_SAMPLE) && r_oob;
        end
    end

    assign o_depth_out = r_depth_out;
    assign o_status    = r_status_out;

    assign o_stat.action       = r_action;
    assign o_stat.oob          = item_oob;
    assign o_stat.single_level = (level_n == t_level'(1));
    assign o_stat.row_end      = row_end;
    assign o_stat.build_end    = build_end;

endmodule

// File: sv/hiz_min_depth_pyramid.sv
// Top level of the hierarchical-Z min-depth pyramid block.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake          Contents
//  i_req     in         valid / ready      action, pyramid_select, mip_level,
//                                          coord_x, coord_y, depth_in
//  o_rsp     out        valid / ready      depth_out, status
//  i_cfg_*   in         write enable only  frame_width (index 0), frame_height (1)
//
// A write or an in-range sample steps from acceptance through address calculation, one store
// access and the response load; a sample off the pyramid, the spare action or a build of a
// one-level pyramid skips the store access and goes straight to the response load.
// Any other build adds a row step for each output row and, for each output texel, two
// reads of the 2x2 block through the store's two read ports and a write of its minimum.
// Reset is synchronous and active low, restores the frame sizes and empties the response
// register. An untaken response holds the controller until it is loaded.

module hiz_min_depth_pyramid #(
    parameter int MAX_WIDTH  = hzp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hzp_pkg::DEF_MAX_HEIGHT,
    parameter int DEPTH_BITS = hzp_pkg::DEF_DEPTH_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hzp_req_if.sink                        i_req,
    hzp_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [hzp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hzp_pkg::DIM_W-1:0]      i_cfg_data
);
    import hzp_pkg::*;

    t_hzp_cmd  cmd;
    t_hzp_stat stat;
    logic      req_ready;
    logic      rsp_valid;

    // The controller sequences each request; the datapath owns all storage.
    hzp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    hzp_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_req.action),
        .i_pyramid_select (i_req.pyramid_select),
        .i_mip_level      (i_req.mip_level),
        .i_coord_x        (i_req.coord_x),
        .i_coord_y        (i_req.coord_y),
        .i_depth_in       (i_req.depth_in),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_depth_out      (o_rsp.depth_out),
        .o_status         (o_rsp.status)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;

endmodule

// File: dv/hiz_depth_checker.sv
// Response checker for the hierarchical-Z pyramid: tracks both pyramids and compares responses.
`timescale 1ns / 1ps

module hiz_depth_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hzp_req_if                            i_req,
    hzp_rsp_if                            i_rsp,
    input  logic                          i_cfg_we,
    input  logic [hzp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hzp_pkg::DIM_W-1:0]     i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);
    import hzp_pkg::*;

    localparam int MAXW = DEF_MAX_WIDTH;
    localparam int MAXH = DEF_MAX_HEIGHT;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               status;
    } t_answer;

    // Extent of a level: the base extent halved lvl times, rounding up.
    function automatic int halve_span(input int base, input int lvl);
        int v;
        v = base;
        for (int i = 0; i < lvl; i++) begin
            v = (v + 1) / 2;
        end
        return v;
    endfunction

    // First word of a level, with every level laid out for the largest frame.
    function automatic int mip_base(input int lvl);
        int off;
        off = 0;
        for (int k = 0; k < lvl; k++) begin
            off += halve_span(MAXW, k) * halve_span(MAXH, k);
        end
        return off;
    endfunction

    localparam int PYR_WORDS = mip_base(NUM_LEVEL_SLOTS);

    bit [DEPTH_W-1:0] texel_mem [2][PYR_WORDS];
    int               frame_w = MAXW;
    int               frame_h = MAXH;
    t_answer          answers_q[$];
    int               mismatches = 0;
    int               outstanding = 0;

    assign o_errors  = mismatches;
    assign o_pending = outstanding;

    function automatic int clamp_dim(input int raw, input int maxv);
        if (raw < 1) begin
            return 1;
        end
        if (raw > maxv) begin
            return maxv;
        end
        return raw;
    endfunction

    function automatic int mip_count();
        int s;
        int n;
        s = (frame_w > frame_h) ? frame_w : frame_h;
        n = 1;
        while (s > 1) begin
            s = (s + 1) / 2;
            n++;
        end
        return n;
    endfunction

    // Each upper texel takes the minimum of the 2x2 block below, clamped at odd edges.
    function automatic void rebuild_levels(input int sel);
        int pw, ph, ow, oh, pbase, obase;
        int x0, x1, y0, y1;
        bit [DEPTH_W-1:0] m;
        for (int l = 1; l < mip_count(); l++) begin
            pw    = halve_span(frame_w, l - 1);
            ph    = halve_span(frame_h, l - 1);
            ow    = halve_span(frame_w, l);
            oh    = halve_span(frame_h, l);
            pbase = mip_base(l - 1);
            obase = mip_base(l);
            for (int y = 0; y < oh; y++) begin
                for (int x = 0; x < ow; x++) begin
                    x0 = (2 * x < pw - 1) ? 2 * x : pw - 1;
                    x1 = (x0 + 1 < pw - 1) ? x0 + 1 : pw - 1;
                    y0 = (2 * y < ph - 1) ? 2 * y : ph - 1;
                    y1 = (y0 + 1 < ph - 1) ? y0 + 1 : ph - 1;
                    m = texel_mem[sel][pbase + y0 * pw + x0];
                    if (texel_mem[sel][pbase + y0 * pw + x1] < m) begin
                        m = texel_mem[sel][pbase + y0 * pw + x1];
                    end
                    if (texel_mem[sel][pbase + y1 * pw + x0] < m) begin
                        m = texel_mem[sel][pbase + y1 * pw + x0];
                    end
                    if (texel_mem[sel][pbase + y1 * pw + x1] < m) begin
                        m = texel_mem[sel][pbase + y1 * pw + x1];
                    end
                    texel_mem[sel][obase + y * ow + x] = m;
                end
            end
        end
    endfunction

    // Applies one request to the tracked pyramids and returns the response it must get.
    function automatic t_answer answer_request(input t_action act, input int sel,
                                               input int lvl, input int x, input int y,
                                               input logic [DEPTH_W-1:0] d);
        t_answer ans;
        int w;
        int h;
        ans = '0;
        case (act)
            ACT_WRITE: begin
                if (x < frame_w && y < frame_h) begin
                    texel_mem[sel][y * frame_w + x] = d;
                end
            end
            ACT_BUILD: begin
                rebuild_levels(sel);
            end
            ACT_SAMPLE: begin
                if (lvl >= mip_count()) begin
                    ans.status = 1'b1;
                end else begin
                    w = halve_span(frame_w, lvl);
                    h = halve_span(frame_h, lvl);
                    if (x >= w || y >= h) begin
                        ans.status = 1'b1;
                    end else begin
                        ans.depth = texel_mem[sel][mip_base(lvl) + y * w + x];
                    end
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic flag(input string msg);
        if (mismatches < 10) begin
            $display("%0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            frame_w = MAXW;
            frame_h = MAXH;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FRAME_WIDTH) begin
                    frame_w = clamp_dim(int'(i_cfg_data), MAXW);
                end else if (i_cfg_index == REG_FRAME_HEIGHT) begin
                    frame_h = clamp_dim(int'(i_cfg_data), MAXH);
                end
            end
            // Responses are retired before the same edge's request is predicted.
            if (i_rsp.valid && i_rsp.ready) begin
                if (answers_q.size() == 0) begin
                    flag($sformatf("response with nothing outstanding: depth %06h status %0d",
                                   i_rsp.depth_out, i_rsp.status));
                end else begin
                    want = answers_q.pop_front();
                    if (i_rsp.depth_out !== want.depth || i_rsp.status !== want.status) begin
                        flag($sformatf({"response mismatch: expected depth %06h status %0d,",
                                        " got depth %06h status %0d"},
                                       want.depth, want.status,
                                       i_rsp.depth_out, i_rsp.status));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                answers_q.push_back(answer_request(i_req.action, int'(i_req.pyramid_select),
                                                   int'(i_req.mip_level), int'(i_req.coord_x),
                                                   int'(i_req.coord_y), i_req.depth_in));
            end
        end
        outstanding = answers_q.size();
    end

endmodule

// File: dv/tb.sv
// Testbench top for the hierarchical-Z pyramid: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb;
    import hzp_pkg::*;

    // The block has no name for the spare action code; it must answer 0 with status 0.
    localparam t_action ACT_UNUSED     = 2'd3;
    // Requests sent over the whole run, directed and random together.
    localparam int      ITEM_BUDGET    = 900;
    // A build on a frame with a 256-pixel edge passes no handshake while it runs, so only
    // a quiet stretch longer than such a build can mean the block is stuck.
    localparam int      WATCHDOG_LIMIT = 5000;
    localparam int      SETTLE_CYCLES  = 8;

    typedef enum {RX_OPEN, RX_STALL, RX_JITTER} t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    t_dim                 cfg_data;
    int                   errors;
    int                   pending;

    hzp_req_if req_if ();
    hzp_rsp_if rsp_if ();

    hiz_min_depth_pyramid u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    hiz_depth_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Frame size as the block sees it, after clamping.
    int cur_w = DEF_MAX_WIDTH;
    int cur_h = DEF_MAX_HEIGHT;

    // The store has no reset value, so the stimulus remembers which base pixels were
    // written (in the layout of whatever frame was active at the time) and whether the
    // upper levels were built for the current frame. Nothing unwritten is ever read:
    // a build needs the whole base of the current frame, an upper-level sample needs
    // a build since the last size change.
    bit base_done [2][65536];
    bit built [2];

    // Sender pacing: bursts of random length separated by random gaps.
    int burst_left = 0;
    // Requests accepted so far.
    int sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The receiver runs its own pattern of open stretches, hard stalls and jitter.
    initial begin
        t_rx_mode mode;
        int       seg_left;
        rsp_if.ready = 1'b0;
        mode = RX_OPEN;
        seg_left = 0;
        forever begin
            @(negedge i_clk);
            if (seg_left == 0) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: begin
                        mode = RX_OPEN;
                        seg_left = $urandom_range(30, 1);
                    end
                    5, 6, 7: begin
                        mode = RX_STALL;
                        seg_left = $urandom_range(6, 1);
                    end
                    default: begin
                        mode = RX_JITTER;
                        seg_left = $urandom_range(20, 1);
                    end
                endcase
            end
            seg_left--;
            case (mode)
                RX_OPEN:  rsp_if.ready <= 1'b1;
                RX_STALL: rsp_if.ready <= 1'b0;
                default:  rsp_if.ready <= 1'($urandom_range(1));
            endcase
        end
    end

    // The watchdog restarts on every handshake on either channel.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** hiz_min_depth_pyramid: FAILED **");
            $finish;
        end
    end

    // Depths lean toward the extremes so that the minimum sees ties and both ends.
    function automatic logic [DEPTH_W-1:0] pick_depth();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return DEPTH_W'($urandom_range(15));
            default: return DEPTH_W'($urandom);
        endcase
    endfunction

    function automatic bit base_full(input int p);
        for (int a = 0; a < cur_w * cur_h; a++) begin
            if (!base_done[p][a]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Presents one request and holds it until the block takes it. At the start of
    // each burst the sender may first idle for a random gap.
    task automatic issue(input t_action act, input int sel, input int lvl,
                         input int x, input int y, input logic [DEPTH_W-1:0] d);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_if.valid          <= 1'b1;
        req_if.action         <= act;
        req_if.pyramid_select <= 1'(sel);
        req_if.mip_level      <= LEVEL_W'(lvl);
        req_if.coord_x        <= COORD_W'(x);
        req_if.coord_y        <= COORD_W'(y);
        req_if.depth_in       <= d;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        sent++;
        if (act == ACT_WRITE && x < cur_w && y < cur_h) begin
            base_done[sel][y * cur_w + x] = 1'b1;
        end
        if (act == ACT_BUILD) begin
            built[sel] = 1'b1;
        end
    endtask

    // Lowers valid and waits until every response already owed has been taken.
    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Resizes the frame while the block is idle. Raw values outside 1..256 are
    // legal on the port and get clamped by the block.
    task automatic set_frame(input int raw_w, input int raw_h);
        drain();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= t_dim'(raw_w);
        @(negedge i_clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= t_dim'(raw_h);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cur_w = (raw_w < 1) ? 1 : ((raw_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : raw_w);
        cur_h = (raw_h < 1) ? 1 : ((raw_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : raw_h);
        // The upper levels now have different extents than the last build produced.
        built[0] = 1'b0;
        built[1] = 1'b0;
    endtask

    // Writes every base pixel of one pyramid and builds it.
    task automatic paint_base(input int p);
        for (int y = 0; y < cur_h; y++) begin
            for (int x = 0; x < cur_w; x++) begin
                issue(ACT_WRITE, p, $urandom_range(15), x, y, pick_depth());
            end
        end
        issue(ACT_BUILD, p, $urandom_range(15), $urandom_range(1023), $urandom_range(1023),
              pick_depth());
    endtask

    // One random request. Most are well formed: writes inside the frame, builds of
    // complete pyramids and samples that land on written texels. The rest are samples
    // off the pyramid, dropped writes and the spare action; the last two are merely
    // ignored by the block and do not count.
    task automatic random_item(output bit counted);
        int roll, p, lc, lvl, ew, eh, x, y;
        roll = $urandom_range(99);
        p = $urandom_range(1);
        counted = 1'b1;
        lc = int'(hzp_level_count(t_dim'((cur_w > cur_h) ? cur_w : cur_h)));
        if (roll < 8 && (base_full(p) || base_full(1 - p))) begin
            if (!base_full(p)) begin
                p = 1 - p;
            end
            issue(ACT_BUILD, p, $urandom_range(15), $urandom_range(1023), $urandom_range(1023),
                  pick_depth());
        end else if (roll < 45) begin
            issue(ACT_WRITE, p, $urandom_range(15), $urandom_range(cur_w - 1),
                  $urandom_range(cur_h - 1), pick_depth());
        end else if (roll < 88) begin
            lvl = built[p] ? $urandom_range(lc - 1) : 0;
            ew = int'(hzp_extent(t_dim'(cur_w), t_level'(lvl)));
            eh = int'(hzp_extent(t_dim'(cur_h), t_level'(lvl)));
            x = $urandom_range(ew - 1);
            y = $urandom_range(eh - 1);
            // A base pixel that was never written is pushed off the level instead.
            if (lvl == 0 && !base_done[p][y * cur_w + x]) begin
                x = $urandom_range(1023, ew);
            end
            issue(ACT_SAMPLE, p, lvl, x, y, pick_depth());
        end else if (roll < 95) begin
            lvl = $urandom_range(lc - 1);
            ew = int'(hzp_extent(t_dim'(cur_w), t_level'(lvl)));
            eh = int'(hzp_extent(t_dim'(cur_h), t_level'(lvl)));
            x = $urandom_range(1023);
            y = $urandom_range(1023);
            case ($urandom_range(2))
                0:       lvl = $urandom_range(15, lc);
                1:       x = $urandom_range(1023, ew);
                default: y = $urandom_range(1023, eh);
            endcase
            issue(ACT_SAMPLE, p, lvl, x, y, pick_depth());
        end else if (roll < 98) begin
            counted = 1'b0;
            if ($urandom_range(1) == 0) begin
                issue(ACT_WRITE, p, $urandom_range(15), $urandom_range(1023, cur_w),
                      $urandom_range(1023), pick_depth());
            end else begin
                issue(ACT_WRITE, p, $urandom_range(15), $urandom_range(1023),
                      $urandom_range(1023, cur_h), pick_depth());
            end
        end else begin
            counted = 1'b0;
            issue(ACT_UNUSED, p, $urandom_range(15), $urandom_range(1023), $urandom_range(1023),
                  pick_depth());
        end
    endtask

    // A phase resizes the frame, repaints the chosen pyramids and then runs a random
    // mix, which also stops once the whole run has used its request budget. Pyramids
    // that are not repainted keep whatever the store held under the old size.
    // Halfway through, the sender waits for every response once.
    task automatic run_phase(input int raw_w, input int raw_h, input bit [1:0] paint,
                             input int count);
        bit counted;
        int done;
        set_frame(raw_w, raw_h);
        for (int p = 0; p < 2; p++) begin
            if (paint[p]) begin
                paint_base(p);
            end
        end
        done = 0;
        while (done < count && sent < ITEM_BUDGET) begin
            random_item(counted);
            if (counted) begin
                done++;
                if (done == count / 2) begin
                    drain();
                end
            end
        end
    endtask

    initial begin
        int raw_w;
        int raw_h;
        bit [1:0] paint;
        req_if.valid          = 1'b0;
        req_if.action         = ACT_WRITE;
        req_if.pyramid_select = 1'b0;
        req_if.mip_level      = '0;
        req_if.coord_x        = '0;
        req_if.coord_y        = '0;
        req_if.depth_in       = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        i_rst_n   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on a 3x1 frame: three levels (3x1, 2x1, 1x1), so the second
        // texel of level 1 clamps onto the last base column.
        set_frame(3, 1);
        issue(ACT_WRITE, 0, 0, 0, 0, 24'hFFFFFF);
        issue(ACT_WRITE, 0, 15, 1, 0, 24'h000000);
        issue(ACT_WRITE, 0, 0, 2, 0, 24'h123456);
        issue(ACT_WRITE, 1, 0, 0, 0, 24'h000001);
        issue(ACT_WRITE, 1, 0, 1, 0, 24'h800000);
        issue(ACT_WRITE, 1, 0, 2, 0, 24'hFFFFFF);
        // Writes just past the right and bottom edges, and at the far corner, are dropped.
        issue(ACT_WRITE, 0, 0, 3, 0, 24'h000000);
        issue(ACT_WRITE, 1, 0, 0, 1, 24'h000000);
        issue(ACT_WRITE, 0, 15, 1023, 1023, 24'h000000);
        issue(ACT_BUILD, 0, 0, 0, 0, 24'h000000);
        issue(ACT_BUILD, 1, 15, 1023, 1023, 24'hFFFFFF);
        issue(ACT_SAMPLE, 0, 0, 2, 0, 24'h000000);
        issue(ACT_SAMPLE, 0, 1, 0, 0, 24'h000000);
        issue(ACT_SAMPLE, 0, 1, 1, 0, 24'h000000);
        issue(ACT_SAMPLE, 0, 2, 0, 0, 24'h000000);
        issue(ACT_SAMPLE, 1, 1, 1, 0, 24'h000000);
        issue(ACT_SAMPLE, 1, 2, 0, 0, 24'hFFFFFF);
        // Samples off the pyramid: level equal to the level count, the highest level
        // code, a column just past level 1, a row past the base and the far column.
        issue(ACT_SAMPLE, 0, 3, 0, 0, 24'h000000);
        issue(ACT_SAMPLE, 1, 15, 1023, 1023, 24'h000000);
        issue(ACT_SAMPLE, 0, 1, 2, 0, 24'h000000);
        issue(ACT_SAMPLE, 0, 0, 0, 1, 24'h000000);
        issue(ACT_SAMPLE, 1, 0, 1023, 0, 24'h000000);
        // The spare action with every field at its top.
        issue(ACT_UNUSED, 1, 15, 1023, 1023, 24'hFFFFFF);

        // Random part. The phases after the first hit the register extremes: a zero width that
        // clamps to one with an oversized height, then an oversized width with one row.
        // Only the tall frame is painted, on one pyramid; the wide frame builds from the
        // same 256 base words left in the store.
        run_phase(5, 3, 2'b11, 80);
        run_phase(0, 511, 2'b10, 40);
        run_phase(300, 1, 2'b00, 40);
        run_phase(1, 1, 2'b00, 20);
        while (sent < ITEM_BUDGET) begin
            if ($urandom_range(4) == 0) begin
                raw_w = $urandom_range(40, 17);
                raw_h = $urandom_range(4, 1);
            end else begin
                raw_w = $urandom_range(16, 1);
                raw_h = $urandom_range(16, 1);
            end
            if ($urandom_range(1) == 0) begin
                int tmp;
                tmp = raw_w;
                raw_w = raw_h;
                raw_h = tmp;
            end
            // Sometimes nothing is repainted, so samples and builds run on the layout
            // left behind by an earlier frame size. Near the end of the budget a full
            // repaint would overrun it, so the base is left as it is.
            paint = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b11;
            if (sent + 2 * (raw_w * raw_h + 1) > ITEM_BUDGET) begin
                paint = 2'b00;
            end
            run_phase(raw_w, raw_h, paint, 60);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("** hiz_min_depth_pyramid: PASSED **");
        end else begin
            $display("** hiz_min_depth_pyramid: FAILED **");
        end
        $finish;
    end

endmodule
